// ===== rtl/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg: shared types and constants for rotation matrix to quaternion
// Fixed point formats, word structs and internal widths.
// ----------------------------------------------------------------------------
package rmq_pkg;

	localparam int FRAC_BITS = 14;
	localparam int NSTEP     = 16;
	localparam int SW        = ((FRAC_BITS > 16) ? FRAC_BITS : 16) + 3;
	localparam int PW        = 2 * (SW - 1) + FRAC_BITS + 4;
	localparam int NLANE     = 4;

	localparam logic [15:0] POS_LIMIT = 16'h7fff;

	localparam logic [1:0] BR_TRACE = 2'd0;
	localparam logic [1:0] BR_X     = 2'd1;
	localparam logic [1:0] BR_Y     = 2'd2;
	localparam logic [1:0] BR_Z     = 2'd3;

	typedef struct packed {
		logic signed [15:0] r00;
		logic signed [15:0] r01;
		logic signed [15:0] r02;
		logic signed [15:0] r10;
		logic signed [15:0] r11;
		logic signed [15:0] r12;
		logic signed [15:0] r20;
		logic signed [15:0] r21;
		logic signed [15:0] r22;
	} mat_t;

	typedef struct packed {
		logic signed [15:0] qx;
		logic signed [15:0] qy;
		logic signed [15:0] qz;
		logic signed [15:0] qw;
		logic [1:0]         branch_taken;
		logic               degenerate;
	} quat_t;

	typedef struct packed {
		logic [15:0]        n;
		logic signed [PW-1:0] p;
		logic signed [PW-1:0] q;
		logic signed [PW-1:0] rhs;
		logic               neg;
	} lane_t;

	typedef struct packed {
		logic signed [SW-1:0] s;
		logic [1:0]           br;
		logic                 degen;
	} item_t;

endpackage

// ===== rtl/rotation_matrix_to_quaternion_top.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top: matrix to quaternion converter
// Takes one matrix word per clock and returns one quaternion word for each
// word taken, through one branch select stage, one squaring stage, sixteen
// bit search stages and one output stage. busy is never asserted, so a
// new word may be started on every clock; done marks each result for exactly
// one clock and cannot be held off. Components are exact, rounded half away
// from zero and saturated; a non-positive scale gives zeros and degenerate.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_top
	import rmq_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	input  mat_t  matrix,
	output logic  done,
	output quat_t result
);

	typedef logic signed [SW-1:0] sv_t;

	sv_t         e00, e01, e02, e10, e11, e12, e20, e21, e22, tr;
	sv_t         s_c, vx_c, vy_c, vz_c, vw_c;
	logic [1:0]  br_c;

	logic        vld_s1;
	item_t       it_s1;
	sv_t         v_s1 [NLANE];

	logic        vld_s [0:NSTEP];
	item_t       it_s  [0:NSTEP];
	lane_t       ln_s  [0:NSTEP][NLANE];
	lane_t       ln_nx [0:NSTEP-1][NLANE];

	logic [SW-2:0] av [NLANE];
	logic [2*(SW-1)-1:0] vv [NLANE];
	logic signed [15:0] comp [NLANE];

	assign busy = 1'b0;

	always_comb begin
		e00 = SW'(matrix.r00); e01 = SW'(matrix.r01); e02 = SW'(matrix.r02);
		e10 = SW'(matrix.r10); e11 = SW'(matrix.r11); e12 = SW'(matrix.r12);
		e20 = SW'(matrix.r20); e21 = SW'(matrix.r21); e22 = SW'(matrix.r22);
		tr  = e00 + e11 + e22;
		if (tr > 0) begin
			br_c = BR_TRACE;
			s_c  = sv_t'(1 <<< FRAC_BITS) + tr;
			vx_c = e21 - e12; vy_c = e02 - e20; vz_c = e10 - e01; vw_c = s_c;
		end else if (e00 > e11 && e00 > e22) begin
			br_c = BR_X;
			s_c  = sv_t'(1 <<< FRAC_BITS) + e00 - e11 - e22;
			vx_c = s_c; vy_c = e01 + e10; vz_c = e02 + e20; vw_c = e21 - e12;
		end else if (e11 > e22) begin
			br_c = BR_Y;
			s_c  = sv_t'(1 <<< FRAC_BITS) + e11 - e00 - e22;
			vx_c = e01 + e10; vy_c = s_c; vz_c = e12 + e21; vw_c = e02 - e20;
		end else begin
			br_c = BR_Z;
			s_c  = sv_t'(1 <<< FRAC_BITS) + e22 - e00 - e11;
			vx_c = e02 + e20; vy_c = e12 + e21; vz_c = s_c; vw_c = e10 - e01;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		it_s1.s     <= s_c;
		it_s1.br    <= br_c;
		it_s1.degen <= (s_c <= 0);
		v_s1[0]     <= vx_c;
		v_s1[1]     <= vy_c;
		v_s1[2]     <= vz_c;
		v_s1[3]     <= vw_c;
	end

	always_comb begin
		for (int l = 0; l < NLANE; l++) begin
			av[l] = v_s1[l][SW-1] ? (SW-1)'(-v_s1[l]) : v_s1[l][SW-2:0];
			vv[l] = av[l] * av[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		it_s[0] <= it_s1;
		for (int l = 0; l < NLANE; l++) begin
			ln_s[0][l].n   <= '0;
			ln_s[0][l].p   <= PW'(it_s1.s);
			ln_s[0][l].q   <= -PW'(it_s1.s);
			ln_s[0][l].rhs <= PW'(vv[l]) <<< (FRAC_BITS + 2);
			ln_s[0][l].neg <= v_s1[l][SW-1];
		end
	end

	for (genvar i = 0; i < NSTEP; i++) begin : g_step
		localparam int B = NSTEP - 1 - i;

		always_comb begin
			logic signed [PW-1:0] ps, pt, qt;
			for (int l = 0; l < NLANE; l++) begin
				ps = PW'(it_s[i].s);
				pt = ln_s[i][l].p + (ln_s[i][l].q <<< (B + 2)) + (ps <<< (2 * B + 2));
				qt = ln_s[i][l].q + (ps <<< (B + 1));
				ln_nx[i][l] = ln_s[i][l];
				if (!ln_s[i][l].n[NSTEP-1] && pt <= ln_s[i][l].rhs) begin
					ln_nx[i][l].n    = ln_s[i][l].n | (16'd1 << B);
					ln_nx[i][l].p    = pt;
					ln_nx[i][l].q    = qt;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			it_s[i+1] <= it_s[i];
			for (int l = 0; l < NLANE; l++) begin
				ln_s[i+1][l] <= ln_nx[i][l];
			end
		end
	end

	always_comb begin
		for (int l = 0; l < NLANE; l++) begin
			if (it_s[NSTEP].degen) begin
				comp[l] = '0;
			end else if (ln_s[NSTEP][l].neg) begin
				comp[l] = -ln_s[NSTEP][l].n;
			end else if (ln_s[NSTEP][l].n > POS_LIMIT) begin
				comp[l] = POS_LIMIT;
			end else begin
				comp[l] = ln_s[NSTEP][l].n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s[NSTEP];
		end
	end

	always_ff @(posedge clk) begin
		result.qx           <= comp[0];
		result.qy           <= comp[1];
		result.qz           <= comp[2];
		result.qw           <= comp[3];
		result.branch_taken <= it_s[NSTEP].br;
		result.degenerate   <= it_s[NSTEP].degen;
	end

`ifndef SYNTH
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.degenerate |-> result.qx == 0 && result.qy == 0 &&
		result.qz == 0 && result.qw == 0)
		else $error("degenerate word with nonzero component");

	a_trace_not_degen: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.branch_taken == BR_TRACE |-> !result.degenerate)
		else $error("trace branch flagged degenerate");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> ##(NSTEP + 2) done)
		else $error("word lost in pipeline");
`endif

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for rotation_matrix_to_quaternion_top
// Sends matrix words through a start/busy handshake with random idle bursts
// and checks each quaternion word against an exact bit-level predictor that
// covers every branch, rounding, saturation and the degenerate-scale case.
// ----------------------------------------------------------------------------
module tb_top
	import rmq_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	mat_t  matrix;
	logic  done;
	quat_t result;

	mat_t  pending_mats[$];
	quat_t expected_quats[$];
	int    mismatches;
	bit    feeding_done;
	int    gap_left;
	bit    no_gaps;

	rotation_matrix_to_quaternion_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.matrix (matrix),
		.done   (done),
		.result (result)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// largest n <= 32768 with (2n-1)^2 * s <= 4*ONE*v^2
	function automatic logic [15:0] scale_component(longint v, longint s);
		longint unsigned av;
		longint unsigned vv;
		longint unsigned n;
		longint unsigned t;
		longint unsigned k;
		longint unsigned d;
		av = (v < 0) ? -v : v;
		vv = av * av;
		d = 4 * (64'd1 << FRAC_BITS);
		n = 0;
		for (int b = 15; b >= 0; b--) begin
			t = n | (64'd1 << b);
			if (t <= 32768) begin
				k = 2 * t - 1;
				if ((k * k * s + d - 1) / d <= vv)
					n = t;
			end
		end
		if (v < 0)
			return 16'(-n);
		if (n > 32767)
			n = 32767;
		return 16'(n);
	endfunction

	function automatic quat_t convert_matrix(mat_t m);
		quat_t  q;
		longint trace;
		longint s;
		longint vx;
		longint vy;
		longint vz;
		longint vw;
		longint one;
		one = longint'(1) << FRAC_BITS;
		trace = longint'(m.r00) + m.r11 + m.r22;
		if (trace > 0) begin
			q.branch_taken = BR_TRACE;
			s = one + trace;
			vx = longint'(m.r21) - m.r12; vy = longint'(m.r02) - m.r20;
			vz = longint'(m.r10) - m.r01; vw = s;
		end else if (m.r00 > m.r11 && m.r00 > m.r22) begin
			q.branch_taken = BR_X;
			s = one + m.r00 - m.r11 - m.r22;
			vx = s; vy = longint'(m.r01) + m.r10;
			vz = longint'(m.r02) + m.r20; vw = longint'(m.r21) - m.r12;
		end else if (m.r11 > m.r22) begin
			q.branch_taken = BR_Y;
			s = one + m.r11 - m.r00 - m.r22;
			vx = longint'(m.r01) + m.r10; vy = s;
			vz = longint'(m.r12) + m.r21; vw = longint'(m.r02) - m.r20;
		end else begin
			q.branch_taken = BR_Z;
			s = one + m.r22 - m.r00 - m.r11;
			vx = longint'(m.r02) + m.r20; vy = longint'(m.r12) + m.r21;
			vz = s; vw = longint'(m.r10) - m.r01;
		end
		if (s <= 0) begin
			q.qx = '0; q.qy = '0; q.qz = '0; q.qw = '0;
			q.degenerate = 1'b1;
		end else begin
			q.qx = scale_component(vx, s);
			q.qy = scale_component(vy, s);
			q.qz = scale_component(vz, s);
			q.qw = scale_component(vw, s);
			q.degenerate = 1'b0;
		end
		return q;
	endfunction

	function automatic logic [15:0] random_entry();
		case ($urandom_range(0, 5))
			0: return 16'h8000 + 16'($urandom_range(0, 3));
			1: return 16'h7fff - 16'($urandom_range(0, 3));
			2: return 16'($urandom);
			default: return 16'($signed($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	function automatic mat_t random_rotation();
		mat_t m;
		int   a;
		int   b;
		int   c;
		int   d;
		a = $urandom_range(0, 16384) - 8192;
		b = $urandom_range(0, 16384) - 8192;
		c = $urandom_range(0, 16384) - 8192;
		d = $urandom_range(0, 16384) - 8192;
		// build from a quaternion with independently random components; its norm is not normalised
		m.r00 = 16'(16384 - (2 * (b * b + c * c)) / 8192);
		m.r11 = 16'(16384 - (2 * (a * a + c * c)) / 8192);
		m.r22 = 16'(16384 - (2 * (a * a + b * b)) / 8192);
		m.r01 = 16'((2 * (a * b - c * d)) / 8192);
		m.r10 = 16'((2 * (a * b + c * d)) / 8192);
		m.r02 = 16'((2 * (a * c + b * d)) / 8192);
		m.r20 = 16'((2 * (a * c - b * d)) / 8192);
		m.r12 = 16'((2 * (b * c - a * d)) / 8192);
		m.r21 = 16'((2 * (b * c + a * d)) / 8192);
		return m;
	endfunction

	function automatic mat_t diag_matrix(int d0, int d1, int d2, int off);
		mat_t m;
		m = '{default: 16'(off)};
		m.r00 = 16'(d0); m.r11 = 16'(d1); m.r22 = 16'(d2);
		m.r21 = 16'(-off); m.r02 = 16'(off + 100);
		return m;
	endfunction

	initial begin
		mat_t m;
		pending_mats.push_back('0);
		pending_mats.push_back('{default: 16'h7fff});
		pending_mats.push_back('{default: 16'h8000});
		pending_mats.push_back(diag_matrix(16384, 16384, 16384, 0));
		pending_mats.push_back(diag_matrix(16384, -16384, -16384, 0));
		pending_mats.push_back(diag_matrix(-16384, 16384, -16384, 0));
		pending_mats.push_back(diag_matrix(-16384, -16384, 16384, 0));
		pending_mats.push_back(diag_matrix(-16384, -16384, -16384, 300));
		pending_mats.push_back(diag_matrix(-20000, -20000, -20000, 7));
		pending_mats.push_back(diag_matrix(5, 5, -10, 1));
		pending_mats.push_back(diag_matrix(0, 0, 0, 1));
		pending_mats.push_back(diag_matrix(-100, -100, -100, 2));
		pending_mats.push_back(diag_matrix(32767, -32768, -32768, 32767));
		pending_mats.push_back(diag_matrix(-32768, 32767, -32768, -32768));
		pending_mats.push_back(diag_matrix(-32768, -32768, 32767, 32767));
		pending_mats.push_back(diag_matrix(-30000, -30000, 32767, -32768));
		pending_mats.push_back(diag_matrix(1, 0, 0, 32767));
		pending_mats.push_back(diag_matrix(-8000, 0, 0, 16000));
		pending_mats.push_back(diag_matrix(16384, 0, 0, -32768));
		pending_mats.push_back(diag_matrix(-1, -1, 2, 100));
		for (int i = 0; i < 1200; i++) begin
			if ($urandom_range(0, 9) < 7)
				m = random_rotation();
			else
				for (int j = 0; j < 9; j++)
					m[j*16 +: 16] = random_entry();
			pending_mats.push_back(m);
		end
		feeding_done = 1'b1;
	end

	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start    <= 1'b0;
			matrix   <= '0;
			gap_left <= 0;
		end else begin
			if (start && !busy)
				expected_quats.push_back(convert_matrix(matrix));
			if (start && busy) begin
				// hold the word until taken
			end else if (gap_left > 0) begin
				start    <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_mats.size() > 0) begin
				if (!no_gaps && $urandom_range(0, 7) == 0) begin
					start    <= 1'b0;
					gap_left <= $urandom_range(1, 16) - 1;
				end else begin
					start  <= 1'b1;
					matrix <= pending_mats.pop_front();
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		quat_t want;
		if (arst_n && done) begin
			if (expected_quats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: %h", result);
			end else begin
				want = expected_quats.pop_front();
				if (want.qx !== result.qx || want.qy !== result.qy ||
				    want.qz !== result.qz || want.qw !== result.qw ||
				    want.branch_taken !== result.branch_taken ||
				    want.degenerate !== result.degenerate) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h actual %h", want, result);
				end
			end
		end
	end

	initial begin
		mismatches   = 0;
		no_gaps      = 1'b0;
		wait (feeding_done);
		wait (pending_mats.size() < 200);
		no_gaps = 1'b1;
		wait (pending_mats.size() == 0 && !start);
		wait (expected_quats.size() == 0);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && expected_quats.size() == 0)
			$display("rotation_matrix_to_quaternion_top verification clean");
		else
			$display("rotation_matrix_to_quaternion_top verification failed");
		$finish;
	end

	initial begin
		#2ms;
		$display("rotation_matrix_to_quaternion_top verification failed");
		$finish;
	end

endmodule
